// ===== hw/rtl/fqr_pkg.sv =====
// Shared types, codes and widths of the fair-queueing rank scheduler.
package fqr_pkg;

  localparam int ROUND_W   = 32;
  localparam int HANDLE_W  = 16;
  localparam int WEIGHT_W  = 4;
  localparam int FLOW_ID_W = 8;
  localparam int OCC_W     = 7;
  localparam int STATUS_W  = 2;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_FLOW_COUNT  = 256;

  localparam logic [ROUND_W-1:0] ROUND_MAX = '1;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [ROUND_W-1:0]  rank;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                push;
    logic                pop;
    logic [ROUND_W-1:0]  rank;
    logic [HANDLE_W-1:0] handle;
  } queue_cmd_t;

  typedef struct packed {
    logic                seen;
    logic [WEIGHT_W-1:0] weight;
    logic [ROUND_W-1:0]  finish;
  } flow_ent_t;

endpackage

// ===== hw/rtl/fqr_in_if.sv =====
// Input channel: enqueue or dequeue requests.
interface fqr_in_if;
  import fqr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [FLOW_ID_W-1:0] flow_id;
  logic [WEIGHT_W-1:0]  flow_weight;
  logic [HANDLE_W-1:0]  packet_handle;

  modport source (output valid, operation, flow_id, flow_weight, packet_handle,
                  input ready);
  modport sink (input valid, operation, flow_id, flow_weight, packet_handle,
                output ready);
endinterface

// ===== hw/rtl/fqr_out_if.sv =====
// Result channel: status, handle, rank and occupancy of each item.
interface fqr_out_if;
  import fqr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] packet_handle_out;
  logic [ROUND_W-1:0]  rank_out;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, packet_handle_out, rank_out, occupancy,
                  input ready);
  modport sink (input valid, status, packet_handle_out, rank_out, occupancy,
                output ready);
endinterface

// ===== hw/rtl/fqr_flow_table.sv =====
// Per-flow memory of seen flag, weight and last finish round, with a clearing sweep.
module fqr_flow_table #(
  parameter int FLOW_COUNT = fqr_pkg::DEF_FLOW_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [fqr_pkg::FLOW_ID_W-1:0]  flow_id,
  output fqr_pkg::flow_ent_t             rd_data,
  input  logic                           wr_en,
  input  fqr_pkg::flow_ent_t             wr_data,
  output logic                           busy
);
  import fqr_pkg::*;

  localparam int FID_W = $clog2(FLOW_COUNT);

  // Reduce the flow index modulo the table size by conditional subtraction.
  function automatic logic [FID_W-1:0] flow_index(input logic [FLOW_ID_W-1:0] id);
    int rem;
    rem = int'(id);
    for (int k = FLOW_ID_W - 1; k >= 0; k--) begin
      if (rem >= (FLOW_COUNT << k)) begin
        rem = rem - (FLOW_COUNT << k);
      end
    end
    return FID_W'(rem);
  endfunction

  flow_ent_t        mem [FLOW_COUNT];
  flow_ent_t        rd_data_r;
  logic [FID_W-1:0] addr_r;
  logic [FID_W-1:0] clr_addr_r;
  logic             busy_r;
  logic [FID_W-1:0] fid;

  assign fid     = flow_index(flow_id);
  assign rd_data = rd_data_r;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == FID_W'(FLOW_COUNT - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Write back always goes to the entry last read.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[addr_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[fid];
      addr_r    <= fid;
    end
  end

endmodule

// ===== hw/rtl/fqr_cell.sv =====
// One slot of the sorted queue: keeps, takes its left or right neighbor, or takes the new item.
module fqr_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  fqr_pkg::queue_cmd_t cmd,
  input  fqr_pkg::entry_t     prev_ent,
  input  logic                prev_vld,
  input  logic                prev_gt,
  input  fqr_pkg::entry_t     next_ent,
  input  logic                next_vld,
  output fqr_pkg::entry_t     ent,
  output logic                vld,
  output logic                gt
);
  import fqr_pkg::*;

  entry_t ent_r;
  logic   vld_r;

  assign ent = ent_r;
  assign vld = vld_r;
  // Strict compare keeps equal ranks in arrival order.
  assign gt  = !vld_r || (ent_r.rank > cmd.rank);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (cmd.push && gt) begin
      vld_r <= prev_gt ? prev_vld : 1'b1;
    end else if (cmd.pop) begin
      vld_r <= next_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && gt) begin
      ent_r <= prev_gt ? prev_ent : entry_t'{rank: cmd.rank, handle: cmd.handle};
    end else if (cmd.pop) begin
      ent_r <= next_ent;
    end
  end

endmodule

// ===== hw/rtl/fqr_queue.sv =====
// Push-in first-out queue built as a row of sorted cells, with its fill count.
module fqr_queue #(
  parameter int QUEUE_DEPTH = fqr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fqr_pkg::queue_cmd_t                cmd,
  output fqr_pkg::entry_t                    head,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);
  import fqr_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           ent [QUEUE_DEPTH];
  logic             vld [QUEUE_DEPTH];
  logic             gt  [QUEUE_DEPTH];
  logic [CNT_W-1:0] count_r;

  assign head  = ent[0];
  assign count = count_r;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t pe;
    logic   pv;
    logic   pg;
    entry_t ne;
    logic   nv;

    if (i == 0) begin : g_first
      assign pe = '0;
      assign pv = 1'b0;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pe = ent[i-1];
      assign pv = vld[i-1];
      assign pg = gt[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign ne = '0;
      assign nv = 1'b0;
    end else begin : g_inner
      assign ne = ent[i+1];
      assign nv = vld[i+1];
    end

    fqr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .prev_ent (pe),
      .prev_vld (pv),
      .prev_gt  (pg),
      .next_ent (ne),
      .next_vld (nv),
      .ent      (ent[i]),
      .vld      (vld[i]),
      .gt       (gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.pop) begin
      count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/fair_queue_rank_pifo.sv =====
// Top level of the start-time fair-queueing scheduler on a sorted cell queue.
//
// Use: drive requests on in_if (operation 0 enqueues packet_handle for
// flow_id, operation 1 dequeues the smallest rank); take one result per
// request on out_if (status, handle, rank, occupancy after the request).
// Both channels move an item when valid and ready are high at a clock edge.
//
// Flow: the flow table is read when an item is accepted and written back
// in S_CALC, where the rank is computed; the queue insert or pop happens in
// S_INS, which also fills the output register, while the next item is
// accepted and its flow entry read.
//
// Reset: rst_n (synchronous, active low) empties the queue, zeroes the
// virtual round, then a clearing pass writes every flow table entry, one a
// cycle; in_if.ready stays low until it is done.
//
// Stall: a result waits in the output register while out_if.ready is low.
// One more item is still accepted and waits, computed, until the output
// register frees; after that in_if.ready stays low.
module fair_queue_rank_pifo #(
  parameter int QUEUE_DEPTH = fqr_pkg::DEF_QUEUE_DEPTH,
  parameter int FLOW_COUNT  = fqr_pkg::DEF_FLOW_COUNT
) (
  input logic clk,
  input logic rst_n,
  fqr_in_if.sink    in_if,
  fqr_out_if.source out_if
);
  import fqr_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_INS
  } state_t;

  state_t              state_r;

  // Held item fields.
  logic                op_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [ROUND_W-1:0]  rank_r;
  logic                drop_r;

  logic [ROUND_W-1:0]  vround_r;

  // Output register.
  logic                out_valid_r;
  status_t             status_r;
  logic [HANDLE_W-1:0] handle_out_r;
  logic [ROUND_W-1:0]  rank_out_r;
  logic [OCC_W-1:0]    occ_r;

  flow_ent_t           ft_rd;
  flow_ent_t           ft_wr;
  logic                ft_wr_en;
  logic                ft_busy;

  queue_cmd_t          qcmd;
  entry_t              q_head;
  logic [CNT_W-1:0]    q_count;
  logic                q_full;
  logic                q_empty;

  logic                out_free;
  logic                in_fire;
  logic                ins_go;

  logic [ROUND_W-1:0]  rank_nxt;
  logic [WEIGHT_W-1:0] weight_nxt;
  logic [ROUND_W:0]    sum_nxt;
  logic [ROUND_W-1:0]  finish_nxt;
  logic [CNT_W:0]      occ_nxt;

  assign out_free    = !out_valid_r || out_if.ready;
  assign ins_go      = (state_r == S_INS) && out_free;
  assign in_if.ready = !ft_busy && ((state_r == S_IDLE) || ins_go);
  assign in_fire     = in_if.valid && in_if.ready;

  assign q_full  = (q_count == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (q_count == '0);

  // Rank is the later of the virtual round and the flow's last finish.
  assign rank_nxt   = (vround_r > ft_rd.finish) ? vround_r : ft_rd.finish;
  assign weight_nxt = ft_rd.seen ? ft_rd.weight : weight_r;
  assign sum_nxt    = {1'b0, rank_nxt} + (ROUND_W + 1)'(weight_nxt);
  assign finish_nxt = sum_nxt[ROUND_W] ? ROUND_MAX : sum_nxt[ROUND_W-1:0];

  // Register the flow even on a drop; keep its finish round then.
  assign ft_wr_en     = (state_r == S_CALC) && (op_r == OP_ENQ);
  assign ft_wr.seen   = 1'b1;
  assign ft_wr.weight = weight_nxt;
  assign ft_wr.finish = q_full ? ft_rd.finish : finish_nxt;

  assign qcmd.push   = ins_go && (op_r == OP_ENQ) && !drop_r;
  assign qcmd.pop    = ins_go && (op_r == OP_DEQ) && !q_empty;
  assign qcmd.rank   = rank_r;
  assign qcmd.handle = handle_r;

  always_comb begin
    if (qcmd.push) begin
      occ_nxt = {1'b0, q_count} + 1'b1;
    end else if (qcmd.pop) begin
      occ_nxt = {1'b0, q_count} - 1'b1;
    end else begin
      occ_nxt = {1'b0, q_count};
    end
  end

  fqr_flow_table #(
    .FLOW_COUNT (FLOW_COUNT)
  ) u_flow_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .flow_id (in_if.flow_id),
    .rd_data (ft_rd),
    .wr_en   (ft_wr_en),
    .wr_data (ft_wr),
    .busy    (ft_busy)
  );

  fqr_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (qcmd),
    .head  (q_head),
    .count (q_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vround_r    <= '0;
    end else begin
      // Capture the request while its flow entry is read.
      if (in_fire) begin
        op_r     <= in_if.operation;
        weight_r <= in_if.flow_weight;
        handle_r <= in_if.packet_handle;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          rank_r  <= rank_nxt;
          drop_r  <= q_full;
          state_r <= S_INS;
        end
        S_INS: begin
          if (out_free) begin
            state_r <= in_fire ? S_CALC : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Fill the output register when the insert or pop completes.
      if (ins_go) begin
        out_valid_r <= 1'b1;
        occ_r       <= OCC_W'(occ_nxt);
        if (op_r == OP_ENQ) begin
          status_r     <= drop_r ? ST_DROPPED : ST_ACCEPTED;
          handle_out_r <= '0;
          rank_out_r   <= rank_r;
        end else if (q_empty) begin
          status_r     <= ST_EMPTY;
          handle_out_r <= '0;
          rank_out_r   <= '0;
        end else begin
          status_r     <= ST_DEQUEUED;
          handle_out_r <= q_head.handle;
          rank_out_r   <= q_head.rank;
          vround_r     <= q_head.rank;
        end
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.status            = status_r;
  assign out_if.packet_handle_out = handle_out_r;
  assign out_if.rank_out          = rank_out_r;
  assign out_if.occupancy         = occ_r;

endmodule

// ===== dv/fqr_sched_checker.sv =====
// Checker for the fair-queueing scheduler: predicts each item's result and compares it.
module fqr_sched_checker #(
  parameter int QUEUE_DEPTH = fqr_pkg::DEF_QUEUE_DEPTH,
  parameter int FLOW_COUNT  = fqr_pkg::DEF_FLOW_COUNT
) (
  input  logic clk,
  input  logic rst_n,
  fqr_in_if    in_ch,
  fqr_out_if   out_ch,
  output int   mismatch_total,
  output int   results_owed
);
  import fqr_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [ROUND_W-1:0]  rank;
    logic [OCC_W-1:0]    occupancy;
  } sched_result_t;

  // Scheduler state mirrored on the testbench side.
  entry_t              sorted_packets[$];
  logic [ROUND_W-1:0]  vround;
  logic [ROUND_W-1:0]  finish_of[FLOW_COUNT];
  logic [WEIGHT_W-1:0] weight_of[FLOW_COUNT];
  logic                known_flow[FLOW_COUNT];

  sched_result_t awaited_results[$];
  int            mismatch_seen;
  int            result_index;

  // Rank, insert or pop one item and return what the block should report.
  function automatic sched_result_t schedule_item(logic op, logic [FLOW_ID_W-1:0] fid_in,
                                                  logic [WEIGHT_W-1:0] wgt,
                                                  logic [HANDLE_W-1:0] hdl);
    sched_result_t      res;
    int                 fid;
    int                 slot;
    logic [ROUND_W-1:0] rank;
    logic [ROUND_W:0]   sum;
    entry_t             ent;
    res = '0;
    if (op == OP_ENQ) begin
      fid = int'(fid_in) % FLOW_COUNT;
      if (!known_flow[fid]) begin
        known_flow[fid] = 1'b1;
        weight_of[fid]  = wgt;
      end
      rank = (vround > finish_of[fid]) ? vround : finish_of[fid];
      res.rank = rank;
      if (sorted_packets.size() >= QUEUE_DEPTH) begin
        // dropped: flow stays registered, finish round untouched
        res.status = ST_DROPPED;
      end else begin
        sum = {1'b0, rank} + (ROUND_W + 1)'(weight_of[fid]);
        finish_of[fid] = sum[ROUND_W] ? ROUND_MAX : sum[ROUND_W-1:0];
        slot = sorted_packets.size();
        while (slot > 0 && sorted_packets[slot-1].rank > rank) slot--;
        ent.rank   = rank;
        ent.handle = hdl;
        sorted_packets.insert(slot, ent);
        res.status = ST_ACCEPTED;
      end
    end else if (sorted_packets.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      ent = sorted_packets.pop_front();
      vround     = ent.rank;
      res.status = ST_DEQUEUED;
      res.handle = ent.handle;
      res.rank   = ent.rank;
    end
    res.occupancy = OCC_W'(sorted_packets.size());
    return res;
  endfunction

  always @(posedge clk) begin
    sched_result_t exp;
    if (!rst_n) begin
      sorted_packets.delete();
      awaited_results.delete();
      vround = '0;
      for (int i = 0; i < FLOW_COUNT; i++) begin
        finish_of[i]  = '0;
        weight_of[i]  = '0;
        known_flow[i] = 1'b0;
      end
      mismatch_seen = 0;
      result_index  = 0;
    end else begin
      // Compare first: a result never belongs to an item taken on the same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          if (mismatch_seen < 10)
            $display("result %0d arrived with nothing outstanding: ", result_index,
                     "status %0d handle %h rank %h occ %0d",
                     out_ch.status, out_ch.packet_handle_out, out_ch.rank_out,
                     out_ch.occupancy);
          mismatch_seen++;
        end else begin
          exp = awaited_results.pop_front();
          if (out_ch.status !== exp.status || out_ch.packet_handle_out !== exp.handle ||
              out_ch.rank_out !== exp.rank || out_ch.occupancy !== exp.occupancy) begin
            if (mismatch_seen < 10)
              $display("result %0d: ", result_index,
                       "expected status %0d handle %h rank %h occ %0d, ",
                       exp.status, exp.handle, exp.rank, exp.occupancy,
                       "got status %0d handle %h rank %h occ %0d",
                       out_ch.status, out_ch.packet_handle_out, out_ch.rank_out,
                       out_ch.occupancy);
            mismatch_seen++;
          end
        end
        result_index++;
      end
      if (in_ch.valid && in_ch.ready) begin
        exp = schedule_item(in_ch.operation, in_ch.flow_id,
                            in_ch.flow_weight, in_ch.packet_handle);
        awaited_results.insert(awaited_results.size(), exp);
      end
    end
    mismatch_total <= mismatch_seen;
    results_owed   <= awaited_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the scheduler testbench: clock, reset, request stimulus, result stalls and verdict.
module testbench;
  import fqr_pkg::*;

  localparam int QUEUE_DEPTH  = DEF_QUEUE_DEPTH;
  localparam int FLOW_COUNT   = DEF_FLOW_COUNT;
  localparam int RANDOM_ITEMS = 1600;
  localparam int QUIET_TAIL   = 200;   // last items run with no idling on either side
  localparam int DRAIN_CYCLES = 8;     // settle time after the last owed result
  // Longest legal quiet stretch is the post-reset flow-table clear; everything
  // else is an idle or stall burst plus the result latency. Allow plenty.
  localparam int STALL_LIMIT  = 4 * FLOW_COUNT + 1000;

  logic clk;
  logic rst_n;

  fqr_in_if  req_ch ();
  fqr_out_if res_ch ();

  int mismatch_total;
  int results_owed;
  int idle_pct;     // chance per item that the request side idles first
  int stall_pct;    // chance per cycle that the result side starts a stall
  int idle_cycles;

  fair_queue_rank_pifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .FLOW_COUNT (FLOW_COUNT)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (req_ch),
    .out_if(res_ch)
  );

  fqr_sched_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .FLOW_COUNT (FLOW_COUNT)
  ) sched_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (req_ch),
    .out_ch        (res_ch),
    .mismatch_total(mismatch_total),
    .results_owed  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run when no item moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("fair_queue_rank_pifo: mismatch");
        $finish;
      end
    end
  end

  // Result side: hold ready low for bursts of random length.
  initial begin
    int hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        res_ch.ready <= 1'b0;
        hold = $urandom_range(1, 17) - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request item and hold it until the block takes it. Optionally
  // idle the request side first; valid is only lowered when a gap follows.
  task automatic offer(input logic op, input logic [FLOW_ID_W-1:0] fid,
                       input logic [WEIGHT_W-1:0] wgt, input logic [HANDLE_W-1:0] hdl);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.flow_id       <= fid;
    req_ch.flow_weight   <= wgt;
    req_ch.packet_handle <= hdl;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Dequeue with noise on the fields the block ignores for this operation.
  task automatic pop_one();
    offer(OP_DEQ, FLOW_ID_W'($urandom), WEIGHT_W'($urandom), HANDLE_W'($urandom));
  endtask

  initial begin
    logic [FLOW_ID_W-1:0] flow_pool[8];
    logic [FLOW_ID_W-1:0] fid;
    int                   sent;
    int                   phase_no;
    int                   phase_len;
    int                   enq_pct;

    // Drive every input known from time zero; hold reset low, then release it.
    rst_n                <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= OP_ENQ;
    req_ch.flow_id       <= '0;
    req_ch.flow_weight   <= '0;
    req_ch.packet_handle <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty dequeue, weight zero, weight ignored on a known
    // flow, extreme flow ids and handles, rank taken from the virtual round
    // versus from the flow's finish round, and draining back to empty.
    pop_one();
    offer(OP_ENQ, 8'd0,   4'd0,  16'h0000);
    offer(OP_ENQ, 8'd0,   4'd5,  16'hFFFF);
    offer(OP_ENQ, 8'd255, 4'd15, 16'h1234);
    offer(OP_ENQ, 8'd255, 4'd1,  16'hFFFE);
    offer(OP_ENQ, 8'd7,   4'd15, 16'h8001);
    offer(OP_ENQ, 8'd255, 4'd9,  16'h7FFF);
    pop_one();
    pop_one();
    pop_one();
    offer(OP_ENQ, 8'd7,   4'd3,  16'hA5A5);
    offer(OP_ENQ, 8'd100, 4'd8,  16'h5A5A);
    offer(OP_ENQ, 8'd0,   4'd1,  16'h0001);
    repeat (7) pop_one();
    pop_one();

    // Random part in phases: fill the queue past full (drops), run mixed
    // traffic, then drain. Most packets come from a small pool of flows so
    // finish rounds build up and compete with the virtual round.
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase_no % 3)
        0: enq_pct = 90;
        1: enq_pct = 55;
        default: enq_pct = 15;
      endcase
      if (RANDOM_ITEMS - sent <= QUIET_TAIL) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 15;
        endcase
      end
      foreach (flow_pool[i]) flow_pool[i] = FLOW_ID_W'($urandom);
      phase_len = $urandom_range(60, 140);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        // drop all idling for the tail of the run
        if (RANDOM_ITEMS - sent == QUIET_TAIL) begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        if ($urandom_range(0, 99) < enq_pct) begin
          fid = ($urandom_range(0, 3) != 0) ? flow_pool[$urandom_range(0, 7)]
                                             : FLOW_ID_W'($urandom);
          offer(OP_ENQ, fid, WEIGHT_W'($urandom_range(0, 15)), HANDLE_W'($urandom));
        end else begin
          pop_one();
        end
        sent++;
      end
      phase_no++;
    end

    // Drop valid, wait for every owed result, then let the pipe settle.
    req_ch.valid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_total == 0 && results_owed == 0) begin
      $display("fair_queue_rank_pifo: match");
    end else begin
      $display("fair_queue_rank_pifo: mismatch");
    end
    $finish;
  end

endmodule
